/* design/sgni_pkg.sv */
// Shared types, codes and direction tables for the sparse D2Q9 neighbour index block.
package sgni_pkg;

  localparam int IDX_W     = 14;
  localparam int CMD_W     = 2;
  localparam int CLS_W     = 2;
  localparam int KIND_W    = 2;
  localparam int ENTRY_W   = KIND_W + IDX_W;
  localparam int POS_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_DIRS  = 9;
  localparam int DIR_W     = 4;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NBR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POS  = 2'd2;

  localparam logic [CLS_W-1:0] CLS_EMPTY    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_FLUID    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BOUNDARY = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FLUID    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOUNDARY = 2'd2;

  localparam logic RES_NEIGHBOUR = 1'b0;
  localparam logic RES_POSITION  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0]        GRID_SIZE_RESET = 8'd128;
  localparam logic signed [POS_W-1:0] POS_NONE        = -8'sd1;
  localparam logic [DIR_W-1:0]        DIR_LAST        = 4'd8;

  // Direction order of the lattice; y grows downward.
  localparam logic signed [1:0] DIR_X [NUM_DIRS] =
    '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] DIR_Y [NUM_DIRS] =
    '{2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1};

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CLS_W-1:0] pixel_class;
    logic [IDX_W-1:0] cell_index;
  } in_req_t;

  typedef struct packed {
    logic                    result_kind;
    logic [IDX_W-1:0]        neighbour_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    pos_valid;
    logic                    last;
  } out_rsp_t;

endpackage

/* design/sgni_grid_store.sv */
// Grid store memory with its clearing sweep after reset.
module sgni_grid_store
  import sgni_pkg::*;
#(
  parameter int GRID_MAX_SIDE = 128
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         wr_en,
  input  logic [$clog2(GRID_MAX_SIDE*GRID_MAX_SIDE)-1:0] wr_addr,
  input  logic [ENTRY_W-1:0]                           wr_entry,
  input  logic                                         rd_en,
  input  logic [$clog2(GRID_MAX_SIDE*GRID_MAX_SIDE)-1:0] rd_addr,
  output logic [ENTRY_W-1:0]                           rd_entry,
  output logic                                         ready
);

  localparam int CELLS = GRID_MAX_SIDE * GRID_MAX_SIDE;
  localparam int GAW   = $clog2(CELLS);

  logic [ENTRY_W-1:0] mem [CELLS];
  logic [ENTRY_W-1:0] rd_entry_r;
  logic [GAW-1:0]     clr_addr_r;
  logic               clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == GAW'(CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;
  assign ready    = !clr_busy_r;

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !wr_en && !rd_en)
    else $error("grid store accessed during the clearing sweep");

endmodule

/* design/sparse_grid_d2q9_neighbour_index_top.sv */
// Sparse D2Q9 lattice builder and neighbour index lookup, top level.
// A load request gives no result. A position request passes through ST_PREAD and ST_POSOUT
// to its registered result; the next request is taken once the state is back in ST_IDLE.
// A neighbour request gives nine results, one per cycle while out_stall is low, from the
// grid store's single read port; the next request is taken once the run has drained.
// After reset the grid store is swept clear of all GRID_MAX_SIDE*GRID_MAX_SIDE entries (16384 by
// default), during which in_stall stays high; configuration writes are taken throughout.
module sparse_grid_d2q9_neighbour_index_top
  import sgni_pkg::*;
#(
  parameter int GRID_MAX_SIDE = 128,
  parameter int MAX_CELLS     = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int XW     = $clog2(GRID_MAX_SIDE);
  localparam int SW     = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
  localparam int GAW    = $clog2(GRID_MAX_SIDE * GRID_MAX_SIDE);
  localparam int CNTW   = $clog2(MAX_CELLS + 1);
  localparam int CMPW   = ((CNTW > IDX_W) ? CNTW : IDX_W) + 1;
  localparam int PCELLS = 2 * MAX_CELLS;
  localparam int PAW    = $clog2(PCELLS);

  localparam logic [GAW-1:0]  SIDE_G = GAW'(GRID_MAX_SIDE);
  localparam logic [SW-1:0]   SIDE_S = SW'(GRID_MAX_SIDE);
  localparam logic [PAW-1:0]  BND_BASE = PAW'(MAX_CELLS);
  localparam logic [CNTW:0]   CELL_LIMIT = (CNTW + 1)'(MAX_CELLS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREAD,
    ST_POSOUT,
    ST_NBR,
    ST_DRAIN
  } state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   grid_width_r;
  logic [CFG_W-1:0]   grid_height_r;
  logic [CNTW-1:0]    fluid_count_r;
  logic [CNTW-1:0]    boundary_count_r;
  logic [XW-1:0]      scan_col_r;
  logic [XW-1:0]      scan_row_r;

  logic [2*XW-1:0]    pos_mem [PCELLS];
  logic [2*XW-1:0]    pos_q_r;
  logic [PAW-1:0]     pos_addr_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic               cell_ok_r;
  logic [DIR_W-1:0]   k_r;
  logic               s1_valid_r;
  logic               s1_hit_r;
  logic               s1_last_r;
  logic               out_valid_r;
  out_rsp_t           out_data_r;

  logic               grid_ready;
  logic               in_acc;
  logic               adv;
  logic               out_emit;
  logic [SW-1:0]      eff_w;
  logic [SW-1:0]      eff_h;
  logic [SW-1:0]      width_ext;
  logic [SW-1:0]      height_ext;

  logic               load_acc;
  logic               load_keep;
  logic [CNTW:0]      total_cells;
  logic [GAW-1:0]     scan_addr;
  logic [ENTRY_W-1:0] load_entry;
  logic [PAW-1:0]     pos_waddr;
  logic [XW:0]        row_inc;
  logic [XW:0]        col_inc;

  logic [CMPW-1:0]    q_idx;
  logic [CMPW-1:0]    q_loc;
  logic               q_fluid;
  logic               q_bnd;
  logic [PAW-1:0]     q_addr;

  logic [XW-1:0]          cur_x;
  logic [XW-1:0]          cur_y;
  logic signed [XW+1:0]   nx;
  logic signed [XW+1:0]   ny;
  logic                   nb_hit;
  logic [GAW-1:0]         nb_addr;
  logic                   grid_rd_en;
  logic [ENTRY_W-1:0]     grid_entry;
  logic [KIND_W-1:0]      entry_kind;
  logic [IDX_W-1:0]       entry_idx;
  logic [IDX_W-1:0]       nb_result;

  assign width_ext  = SW'(grid_width_r);
  assign height_ext = SW'(grid_height_r);
  assign eff_w = (width_ext == '0) ? SW'(1) : (width_ext > SIDE_S) ? SIDE_S : width_ext;
  assign eff_h = (height_ext == '0) ? SW'(1) : (height_ext > SIDE_S) ? SIDE_S : height_ext;

  assign in_stall = !(state_r == ST_IDLE && grid_ready);
  assign in_acc   = in_valid && !in_stall;
  assign adv      = !out_valid_r || !out_stall;
  assign out_emit = (state_r == ST_POSOUT) ||
                    ((state_r == ST_NBR || state_r == ST_DRAIN) && s1_valid_r);

  // Load path: scan position, index allocation and store writes.
  always_comb begin
    load_acc    = in_acc && (in_data.cmd == CMD_LOAD);
    total_cells = (CNTW + 1)'(fluid_count_r) + (CNTW + 1)'(boundary_count_r);
    load_keep   = (total_cells < CELL_LIMIT) &&
                  (in_data.pixel_class == CLS_FLUID || in_data.pixel_class == CLS_BOUNDARY);
    scan_addr   = GAW'(scan_col_r) * SIDE_G + GAW'(scan_row_r);
    if (!load_keep) begin
      load_entry = '0;
    end else if (in_data.pixel_class == CLS_FLUID) begin
      load_entry = {KIND_FLUID, IDX_W'(fluid_count_r)};
    end else begin
      load_entry = {KIND_BOUNDARY, IDX_W'(boundary_count_r)};
    end
    pos_waddr = (in_data.pixel_class == CLS_FLUID) ? PAW'(fluid_count_r)
                                                  : BND_BASE + PAW'(boundary_count_r);
    row_inc   = {1'b0, scan_row_r} + 1'b1;
    col_inc   = {1'b0, scan_col_r} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= GRID_SIZE_RESET;
      grid_height_r    <= GRID_SIZE_RESET;
      fluid_count_r    <= '0;
      boundary_count_r <= '0;
      scan_col_r       <= '0;
      scan_row_r       <= '0;
    end else begin
      if (cfg_wr_en && cfg_index == REG_GRID_WIDTH) begin
        grid_width_r <= cfg_wdata;
      end
      if (cfg_wr_en && cfg_index == REG_GRID_HEIGHT) begin
        grid_height_r <= cfg_wdata;
      end
      if (load_acc) begin
        if (load_keep && in_data.pixel_class == CLS_FLUID) begin
          fluid_count_r <= fluid_count_r + 1'b1;
        end
        if (load_keep && in_data.pixel_class == CLS_BOUNDARY) begin
          boundary_count_r <= boundary_count_r + 1'b1;
        end
        if (SW'(row_inc) >= eff_h) begin
          scan_row_r <= '0;
          if (SW'(col_inc) >= eff_w) begin
            scan_col_r <= '0;
          end else begin
            scan_col_r <= col_inc[XW-1:0];
          end
        end else begin
          scan_row_r <= row_inc[XW-1:0];
        end
      end
    end
  end

  // Position list: fluid cells in the lower half, boundary cells in the upper half.
  always_ff @(posedge clk) begin
    if (load_acc && load_keep) begin
      pos_mem[pos_waddr] <= {scan_col_r, scan_row_r};
    end
    if (state_r == ST_PREAD) begin
      pos_q_r <= pos_mem[pos_addr_r];
    end
  end

  // Query decode of the combined index.
  always_comb begin
    q_idx   = CMPW'(in_data.cell_index);
    q_loc   = q_idx - CMPW'(fluid_count_r);
    q_fluid = q_idx < CMPW'(fluid_count_r);
    q_bnd   = !q_fluid && (q_loc < CMPW'(boundary_count_r));
    q_addr  = q_fluid ? PAW'(in_data.cell_index) : BND_BASE + PAW'(q_loc);
  end

  // Neighbour address for the direction being issued.
  always_comb begin
    cur_x   = pos_q_r[2*XW-1:XW];
    cur_y   = pos_q_r[XW-1:0];
    nx      = $signed({2'b00, cur_x}) + (XW + 2)'(DIR_X[k_r]);
    ny      = $signed({2'b00, cur_y}) + (XW + 2)'(DIR_Y[k_r]);
    nb_hit  = cell_ok_r && !nx[XW+1] && !ny[XW+1] &&
              (SW'(nx[XW:0]) < eff_w) && (SW'(ny[XW:0]) < eff_h);
    nb_addr = GAW'(nx[XW-1:0]) * SIDE_G + GAW'(ny[XW-1:0]);
    grid_rd_en = (state_r == ST_NBR) && adv && nb_hit;
  end

  sgni_grid_store #(
    .GRID_MAX_SIDE (GRID_MAX_SIDE)
  ) u_grid_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (load_acc),
    .wr_addr  (scan_addr),
    .wr_entry (load_entry),
    .rd_en    (grid_rd_en),
    .rd_addr  (nb_addr),
    .rd_entry (grid_entry),
    .ready    (grid_ready)
  );

  always_comb begin
    entry_kind = grid_entry[ENTRY_W-1:IDX_W];
    entry_idx  = grid_entry[IDX_W-1:0];
    if (!s1_hit_r) begin
      nb_result = idx_r;
    end else if (entry_kind == KIND_FLUID) begin
      nb_result = entry_idx;
    end else if (entry_kind == KIND_BOUNDARY) begin
      nb_result = entry_idx + IDX_W'(fluid_count_r);
    end else begin
      nb_result = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= out_emit;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_data.cmd == CMD_NBR || in_data.cmd == CMD_POS)) begin
            cmd_r      <= in_data.cmd;
            idx_r      <= in_data.cell_index;
            cell_ok_r  <= q_fluid || q_bnd;
            pos_addr_r <= q_addr;
            k_r        <= '0;
            state_r    <= ST_PREAD;
          end
        end
        ST_PREAD: begin
          state_r <= (cmd_r == CMD_NBR) ? ST_NBR : ST_POSOUT;
        end
        ST_POSOUT: begin
          if (adv) begin
            out_data_r.result_kind     <= RES_POSITION;
            out_data_r.neighbour_index <= '0;
            out_data_r.pos_x           <= cell_ok_r ? POS_W'(cur_x) : POS_NONE;
            out_data_r.pos_y           <= cell_ok_r ? POS_W'(cur_y) : POS_NONE;
            out_data_r.pos_valid       <= cell_ok_r;
            out_data_r.last            <= 1'b1;
            state_r                    <= ST_IDLE;
          end
        end
        ST_NBR, ST_DRAIN: begin
          if (adv) begin
            if (s1_valid_r) begin
              out_data_r.result_kind     <= RES_NEIGHBOUR;
              out_data_r.neighbour_index <= nb_result;
              out_data_r.pos_x           <= '0;
              out_data_r.pos_y           <= '0;
              out_data_r.pos_valid       <= 1'b0;
              out_data_r.last            <= s1_last_r;
            end
            if (state_r == ST_NBR) begin
              s1_valid_r <= 1'b1;
              s1_hit_r   <= nb_hit;
              s1_last_r  <= (k_r == DIR_LAST);
              if (k_r == DIR_LAST) begin
                state_r <= ST_DRAIN;
              end else begin
                k_r <= k_r + 1'b1;
              end
            end else begin
              s1_valid_r <= 1'b0;
              state_r    <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cell_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNTW + 1)'(fluid_count_r) + (CNTW + 1)'(boundary_count_r)) <= CELL_LIMIT)
    else $error("cell counts exceed the store capacity");

  a_query_reads_position: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.cmd == CMD_NBR || in_data.cmd == CMD_POS) |=> state_r == ST_PREAD)
    else $error("query request did not start with a position read");

  a_stage_in_neighbour_run: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> state_r == ST_NBR || state_r == ST_DRAIN)
    else $error("neighbour stage holds data outside a neighbour run");

  a_drain_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> s1_valid_r && s1_last_r)
    else $error("neighbour run drained without its final direction");

endmodule
